// ===== hdl/vses_pkg.sv =====
// Shared types, constants and table builders for the variable-step smoother.
`timescale 1ns / 1ps
package vses_pkg;

  localparam int INT_TAB_SIZE = 32;
  localparam int MAC_A_W = 32;
  localparam int MAC_B_W = 36;
  localparam int MAC_CHUNK_W = 18;
  localparam int MAC_P_W = MAC_A_W + MAC_B_W;
  localparam int VAL_W = 36;

  // register indexes on the configuration port
  localparam logic REG_LEVEL_TC = 1'b0;
  localparam logic REG_TREND_TC = 1'b1;

  typedef logic [30:0] q30_t;
  typedef q30_t int_tab_t [INT_TAB_SIZE];

  // exp(-x) in Q30 by a Taylor series up to x^24 with truncating products
  function automatic q30_t exp_series_q30(input logic [63:0] x30);
    logic signed [63:0] sum;
    logic [63:0] term;
    sum = 64'sd1 <<< 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * x30) >> 30) / 64'(k);
      if ((k % 2) == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
    return q30_t'(sum);
  endfunction

  // exp(-n) in Q30 for n below INT_TAB_SIZE
  function automatic int_tab_t build_int_tab();
    int_tab_t tab;
    logic [63:0] e1;
    logic [63:0] p;
    e1 = 64'(exp_series_q30(64'd1 << 30));
    tab[0] = q30_t'(64'd1 << 30);
    for (int i = 1; i < INT_TAB_SIZE; i++) begin
      p = (64'(tab[i-1]) * e1 + (64'd1 << 29)) >> 30;
      tab[i] = q30_t'(p);
    end
    return tab;
  endfunction

  localparam int_tab_t INT_TAB = build_int_tab();

  function automatic logic signed [31:0] sat32(input logic signed [VAL_W-1:0] v);
    if (v > 36'sd2147483647) return 32'sh7fffffff;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ===== hdl/vses_if.sv =====
// Input and result channel interfaces of the smoother.
`timescale 1ns / 1ps
interface vses_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] sample_value;
  logic        [31:0] time_or_step;

  modport source (output valid, func, sample_value, time_or_step, input ready);
  modport sink   (input valid, func, sample_value, time_or_step, output ready);
endinterface

interface vses_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] filtered_level;
  logic signed [31:0] trend_per_step;
  logic               trend_valid;
  logic        [31:0] step_used;

  modport source (output valid, filtered_level, trend_per_step, trend_valid, step_used,
                  input ready);
  modport sink   (input valid, filtered_level, trend_per_step, trend_valid, step_used,
                  output ready);
endinterface

// ===== hdl/variable_step_exp_smoother.sv =====
// Variable-step single/double exponential smoother: sequencer, state and registers.
// Sequence: the first two samples go from S_IDLE straight to S_EMIT. Later samples run the
// divider (N = 33 + clog2(EXP_TABLE_DEPTH) quotient bits) and multiplier for the level coefficient,
// in double mode also for the trend coefficient, then mix; S_EMIT waits while the result port stalls.
// Throughput: a new sample is accepted only in S_IDLE, not before the last one has been emitted.
// Reset: asynchronous, clears level, trend, timestamp, phase and restores register defaults.
`timescale 1ns / 1ps
module variable_step_exp_smoother
  import vses_pkg::*;
#(
  parameter int COEF_FRAC_BITS  = 16,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vses_in_if.sink     in_i,
  vses_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NW    = 33 + $clog2(EXP_TABLE_DEPTH);
  localparam int UW    = $clog2(32 * EXP_TABLE_DEPTH);
  localparam int FIW   = $clog2(EXP_TABLE_DEPTH);
  localparam int CW    = COEF_FRAC_BITS + 1;
  localparam int RS    = 30 - COEF_FRAC_BITS;
  localparam logic [31:0] RHalf = (RS > 0) ? (32'd1 << ((RS > 0) ? RS - 1 : 0)) : 32'd0;
  localparam logic [MAC_P_W-1:0] MHalf = MAC_P_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [NW-1:0] ULimit = NW'(32 * EXP_TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DIVW, S_SPLIT, S_ROM, S_AMUL, S_AMULW, S_STORE,
    S_MIX0, S_MIX0W, S_MIX1, S_MIX1W, S_EMIT
  } state_e;

  state_e state_q;

  logic [31:0] level_tc_q, trend_tc_q;
  logic signed [31:0] level_q, trend_q, x_q;
  logic [31:0] prev_time_q, dt_q;
  logic [1:0]  phase_q;
  logic        sel_g_q, neg_q;
  logic [NW-1:0] u_q;
  logic [4:0]  n_q;
  logic [FIW-1:0] f_q;
  q30_t        frac_q, int_q, a30_q;
  logic [CW-1:0] coef_a_q, coef_g_q;
  logic signed [VAL_W-1:0] e_q;

  logic        out_valid_q, out_tv_q;
  logic signed [31:0] out_lvl_q, out_tr_q;
  logic [31:0] out_step_q;

  // exp(-f/DEPTH) table
  q30_t frac_rom [EXP_TABLE_DEPTH];
  for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_frac
    localparam logic [63:0] X30 =
      ((64'(i) << 30) + 64'(EXP_TABLE_DEPTH / 2)) / 64'(EXP_TABLE_DEPTH);
    assign frac_rom[i] = exp_series_q30(X30);
  end

  // configuration port
  logic wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_TREND_TC) ? trend_tc_q : level_tc_q;

  // divider operands
  logic [31:0]   tc_sel, tc_eff;
  logic [NW-1:0] div_num, div_quo;
  logic          div_start, div_done;
  assign tc_sel    = sel_g_q ? trend_tc_q : level_tc_q;
  assign tc_eff    = (tc_sel == 32'd0) ? 32'd1 : tc_sel;
  assign div_num   = NW'(dt_q) * NW'(EXP_TABLE_DEPTH) + NW'(tc_eff >> 1);
  assign div_start = (state_q == S_DIV);

  vses_div #(.NUM_W(NW)) u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (tc_eff),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // split u into integer and fraction steps of the table
  logic [UW-1:0] split_rem;
  logic [4:0]    split_n;
  always_comb begin
    split_rem = u_q[UW-1:0];
    split_n   = '0;
    for (int b = 4; b >= 0; b--) begin
      if (split_rem >= UW'(EXP_TABLE_DEPTH << b)) begin
        split_rem  = split_rem - UW'(EXP_TABLE_DEPTH << b);
        split_n[b] = 1'b1;
      end
    end
  end

  // smoothing terms
  logic double_mode;
  logic signed [VAL_W-1:0] x36, lvl36, tr36, e_now, v0, v1, v_sel, cm, stp;
  logic [VAL_W-1:0] mag;
  logic [MAC_P_W-1:0] mac_prod;
  logic [VAL_W-1:0] cm_mag;
  logic [31:0] coef_full;
  logic [CW-1:0] coef_new;
  logic [MAC_A_W-1:0] mac_a;
  logic [MAC_B_W-1:0] mac_b;
  logic mac_start, mac_done;

  assign double_mode = (trend_tc_q != 32'd0);
  assign x36   = VAL_W'(x_q);
  assign lvl36 = VAL_W'(level_q);
  assign tr36  = VAL_W'(trend_q);
  assign e_now = x36 - lvl36;
  assign v0    = double_mode ? (lvl36 + tr36 - x36) : e_now;
  assign v1    = tr36 - e_now;
  assign v_sel = (state_q == S_MIX1) ? v1 : v0;
  assign mag   = v_sel[VAL_W-1] ? VAL_W'(-v_sel) : VAL_W'(v_sel);

  assign mac_start = (state_q == S_AMUL) || (state_q == S_MIX0) || (state_q == S_MIX1);
  always_comb begin
    if (state_q == S_AMUL) begin
      mac_a = MAC_A_W'(frac_q);
      mac_b = MAC_B_W'(int_q);
    end else begin
      mac_a = (state_q == S_MIX1) ? MAC_A_W'(coef_g_q) : MAC_A_W'(coef_a_q);
      mac_b = MAC_B_W'(mag);
    end
  end

  vses_mac u_mac (
    .clk_i, .rst_ni,
    .start_i (mac_start),
    .a_i     (mac_a),
    .b_i     (mac_b),
    .done_o  (mac_done),
    .prod_o  (mac_prod)
  );

  assign cm_mag    = VAL_W'((mac_prod + MHalf) >> COEF_FRAC_BITS);
  assign cm        = neg_q ? -$signed(cm_mag) : $signed(cm_mag);
  assign stp       = e_q - cm;
  assign coef_full = (32'(a30_q) + RHalf) >> RS;
  assign coef_new  = CW'(coef_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      level_tc_q  <= 32'd1000;
      trend_tc_q  <= 32'd0;
      level_q     <= '0;
      trend_q     <= '0;
      prev_time_q <= '0;
      phase_q     <= 2'd0;
      sel_g_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (paddr[2])
          REG_LEVEL_TC: level_tc_q <= pwdata;
          REG_TREND_TC: trend_tc_q <= pwdata;
          default: ;
        endcase
      end
      if (out_valid_q && out_o.ready && (state_q != S_EMIT)) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            x_q <= in_i.sample_value;
            if (!in_i.func) begin
              dt_q        <= in_i.time_or_step - prev_time_q;
              prev_time_q <= in_i.time_or_step;
            end else begin
              dt_q <= in_i.time_or_step;
            end
            sel_g_q <= 1'b0;
            priority case (phase_q)
              2'd0: begin
                level_q <= in_i.sample_value;
                phase_q <= 2'd1;
                state_q <= S_EMIT;
              end
              2'd1: begin
                trend_q <= sat32(VAL_W'(in_i.sample_value) - lvl36);
                level_q <= in_i.sample_value;
                phase_q <= 2'd2;
                state_q <= S_EMIT;
              end
              default: state_q <= S_DIV;
            endcase
          end
        end
        S_DIV:  state_q <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            u_q     <= div_quo;
            state_q <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          if (u_q >= ULimit) begin
            // beyond the integer table: coefficient underflows to zero
            a30_q   <= '0;
            state_q <= S_STORE;
          end else begin
            n_q     <= split_n;
            f_q     <= split_rem[FIW-1:0];
            state_q <= S_ROM;
          end
        end
        S_ROM: begin
          frac_q  <= frac_rom[f_q];
          int_q   <= INT_TAB[n_q];
          state_q <= S_AMUL;
        end
        S_AMUL:  state_q <= S_AMULW;
        S_AMULW: begin
          if (mac_done) begin
            a30_q   <= q30_t'((mac_prod + (MAC_P_W'(1) << 29)) >> 30);
            state_q <= S_STORE;
          end
        end
        S_STORE: begin
          if (!sel_g_q) begin
            coef_a_q <= coef_new;
            if (double_mode) begin
              sel_g_q <= 1'b1;
              state_q <= S_DIV;
            end else begin
              state_q <= S_MIX0;
            end
          end else begin
            coef_g_q <= coef_new;
            state_q  <= S_MIX0;
          end
        end
        S_MIX0: begin
          e_q     <= e_now;
          neg_q   <= v_sel[VAL_W-1];
          state_q <= S_MIX0W;
        end
        S_MIX0W: begin
          if (mac_done) begin
            if (double_mode) begin
              level_q <= sat32(x36 + cm);
              state_q <= S_MIX1;
            end else begin
              level_q <= 32'(lvl36 + stp);
              trend_q <= sat32(stp);
              state_q <= S_EMIT;
            end
          end
        end
        S_MIX1: begin
          e_q     <= e_now;
          neg_q   <= v_sel[VAL_W-1];
          state_q <= S_MIX1W;
        end
        S_MIX1W: begin
          if (mac_done) begin
            trend_q <= sat32(e_q + cm);
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          // hold until the output register is free
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_lvl_q   <= level_q;
            out_tv_q    <= (phase_q == 2'd2) || (phase_q == 2'd3);
            out_tr_q    <= ((phase_q == 2'd2) || (phase_q == 2'd3)) ? trend_q : 32'sd0;
            out_step_q  <= dt_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.filtered_level = out_lvl_q;
  assign out_o.trend_per_step = out_tr_q;
  assign out_o.trend_valid    = out_tv_q;
  assign out_o.step_used      = out_step_q;

endmodule

// ===== hdl/vses_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module vses_div #(
  parameter int NUM_W = 41
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [31:0]      den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q, quo_q;
  logic [31:0]      den_q, rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [32:0]      trial;
  logic             fits;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(NUM_W);
        num_q <= num_i;
        den_q <= den_i;
        rem_q <= '0;
        quo_q <= '0;
      end else if (cnt_q != '0) begin
        num_q <= num_q << 1;
        quo_q <= {quo_q[NUM_W-2:0], fits};
        rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== hdl/vses_mac.sv =====
// Shared multiplier: 32 x 36 product from two 32 x 18 partial products (18-bit chunks of b).
`timescale 1ns / 1ps
module vses_mac
  import vses_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MAC_A_W-1:0] a_i,
  input  logic [MAC_B_W-1:0] b_i,
  output logic               done_o,
  output logic [MAC_P_W-1:0] prod_o
);

  localparam int PP_W = MAC_A_W + MAC_CHUNK_W;

  logic [MAC_A_W-1:0] a_q;
  logic [MAC_B_W-1:0] b_q;
  logic [PP_W-1:0]    pp_q;
  logic [MAC_P_W-1:0] acc_q;
  logic [1:0]         step_q;
  logic               done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        a_q    <= a_i;
        b_q    <= b_i;
        step_q <= 2'd1;
      end else begin
        unique case (step_q)
          2'd1: begin
            pp_q   <= a_q * b_q[MAC_CHUNK_W-1:0];
            step_q <= 2'd2;
          end
          2'd2: begin
            acc_q  <= MAC_P_W'(pp_q);
            pp_q   <= a_q * b_q[MAC_B_W-1:MAC_CHUNK_W];
            step_q <= 2'd3;
          end
          2'd3: begin
            acc_q  <= acc_q + (MAC_P_W'(pp_q) << MAC_CHUNK_W);
            step_q <= 2'd0;
            done_q <= 1'b1;
          end
          default: step_q <= 2'd0;
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
